[sv/dual_pid_steer_drive_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the dual PID steer/drive block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef DUAL_PID_STEER_DRIVE_ASSERT_SVH
`define DUAL_PID_STEER_DRIVE_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define DPSD_ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DPSD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define DPSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define DPSD_ASSERT_HOLDS(lbl, clk, rst, cond, msg)
`define DPSD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define DPSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[sv/dpsd_pkg.sv]
// ---------------------------------------------------------------------------
// dpsd_pkg
// Widths, constants, control word format and microcode program for the
// dual PID steer/drive block.
// ---------------------------------------------------------------------------
`default_nettype none

package dpsd_pkg;

   // field widths
   localparam int ERR_W  = 16;
   localparam int GAIN_W = 24;
   localparam int SUM_W  = 32;
   localparam int DIFF_W = ERR_W + 1;
   localparam int CMD_W  = 16;
   localparam int TICK_W = 11;

   // shared multiplier: gain (or span) times a 33 bit operand
   localparam int MB_W   = SUM_W + 1;
   localparam int PROD_W = GAIN_W + MB_W;
   localparam int ACC_W  = PROD_W + 1;

   // PID sums beyond +-2^28 saturate the command for any span, so the
   // sum is clamped there before scaling
   localparam int PID_W   = 30;
   localparam int PID_LIM = 2 ** 28;

   // throttle scaling and integral reset period
   localparam int THROTTLE_SPAN = 1024;
   localparam int THROTTLE_MIN  = 1024;
   localparam int RESET_PERIOD  = 1000;
   localparam int SERVO_SHIFT   = 10;
   localparam int MOTOR_SHIFT   = 8;

   // config port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = GAIN_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_KP   = 3'd0,
      CSR_ANGLE_KI   = 3'd1,
      CSR_ANGLE_KD   = 3'd2,
      CSR_SPEED_KP   = 3'd3,
      CSR_SPEED_KI   = 3'd4,
      CSR_SPEED_KD   = 3'd5,
      CSR_STOP_BOUND = 3'd6
   } csr_index_type;

   // reset values of the gain registers
   localparam logic signed [GAIN_W-1:0] ANGLE_KP_RST = 24'sd2048000;
   localparam logic signed [GAIN_W-1:0] ANGLE_KI_RST = 24'sd0;
   localparam logic signed [GAIN_W-1:0] ANGLE_KD_RST = 24'sd0;
   localparam logic signed [GAIN_W-1:0] SPEED_KP_RST = 24'sd768000;
   localparam logic signed [GAIN_W-1:0] SPEED_KI_RST = 24'sd384;
   localparam logic signed [GAIN_W-1:0] SPEED_KD_RST = 24'sd1280000;
   localparam logic signed [ERR_W-1:0]  STOP_BOUND_RST = 16'sd0;

   // microcode fields
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_LOOP = 4'd1;

   typedef enum logic [1:0] {MA_KP, MA_KI, MA_KD, MA_SPAN} mul_a_type;
   typedef enum logic [1:0] {MB_ERR, MB_SUM, MB_DIFF, MB_PID} mul_b_type;
   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_type;
   typedef enum logic [2:0] {DP_NONE, DP_PREP, DP_CLAMP, DP_SCALE, DP_POST} dp_op_type;
   typedef enum logic [1:0] {SEQ_NEXT, SEQ_LOOP, SEQ_END} seq_op_type;

   typedef struct packed {
      mul_a_type         mul_a;
      mul_b_type         mul_b;
      logic              mul_en;
      acc_op_type        acc_op;
      dp_op_type         dp_op;
      seq_op_type        seq_op;
      logic [STEP_W-1:0] target;
   } ucode_type;

   // sequencer to datapath
   typedef struct packed {
      ucode_type uc;
      logic      active;  // a control word is executing
      logic      chan;    // 0: steering loop, 1: drive loop
   } ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic start;  // item accepted
      logic hold;   // result register still full at the final step
   } seq_status_type;

   typedef enum logic {ST_IDLE, ST_RUN} seq_state_type;

   // control program; steps 1..7 run once per loop, step 7 jumps back
   // to step 1 for the drive loop
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_rom = '{mul_a: MA_KP, mul_b: MB_ERR, mul_en: 1'b0, acc_op: ACC_HOLD,
                    dp_op: DP_NONE, seq_op: SEQ_NEXT, target: '0};
      case (step)
         4'd0: ucode_rom.dp_op = DP_PREP;
         4'd1: begin
            ucode_rom.mul_a  = MA_KP;
            ucode_rom.mul_b  = MB_ERR;
            ucode_rom.mul_en = 1'b1;
         end
         4'd2: begin
            ucode_rom.mul_a  = MA_KI;
            ucode_rom.mul_b  = MB_SUM;
            ucode_rom.mul_en = 1'b1;
            ucode_rom.acc_op = ACC_LOAD;
         end
         4'd3: begin
            ucode_rom.mul_a  = MA_KD;
            ucode_rom.mul_b  = MB_DIFF;
            ucode_rom.mul_en = 1'b1;
            ucode_rom.acc_op = ACC_ADD;
         end
         4'd4: ucode_rom.acc_op = ACC_ADD;
         4'd5: ucode_rom.dp_op = DP_CLAMP;
         4'd6: begin
            ucode_rom.mul_a  = MA_SPAN;
            ucode_rom.mul_b  = MB_PID;
            ucode_rom.mul_en = 1'b1;
         end
         4'd7: begin
            ucode_rom.dp_op  = DP_SCALE;
            ucode_rom.seq_op = SEQ_LOOP;
            ucode_rom.target = STEP_LOOP;
         end
         4'd8: begin
            ucode_rom.dp_op  = DP_POST;
            ucode_rom.seq_op = SEQ_END;
         end
         default: ucode_rom.seq_op = SEQ_END;
      endcase
   endfunction

endpackage

`default_nettype wire

[sv/dpsd_sequencer.sv]
// ---------------------------------------------------------------------------
// dpsd_sequencer
// Step counter, program ROM and loop jump that drive the PID datapath.
// ---------------------------------------------------------------------------
`default_nettype none

`include "dual_pid_steer_drive_assert.svh"

module dpsd_sequencer
   import dpsd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire seq_status_type status,
   output ctrl_type            ctrl
);

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              chan_ff, chan_in;
   ucode_type         uc;

   assign uc = ucode_rom(step_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (status.start) state_in = ST_RUN;
         ST_RUN:  if (uc.seq_op == SEQ_END && !status.hold) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl.uc     = uc;
      ctrl.chan   = chan_ff;
      ctrl.active = 1'b0;
      case (state_ff)
         ST_IDLE: ctrl.active = 1'b0;
         ST_RUN:  ctrl.active = 1'b1;
         default: ctrl.active = 1'b0;
      endcase
   end

   // step counter and loop select
   always_comb begin
      step_in = step_ff;
      chan_in = chan_ff;
      if (state_ff != ST_RUN) begin
         step_in = '0;
         chan_in = 1'b0;
      end else if (!status.hold) begin
         case (uc.seq_op)
            SEQ_NEXT: step_in = STEP_W'(step_ff + 1'b1);
            SEQ_LOOP: begin
               if (!chan_ff) begin
                  step_in = uc.target;
                  chan_in = 1'b1;
               end else begin
                  step_in = STEP_W'(step_ff + 1'b1);
               end
            end
            SEQ_END: begin
               step_in = '0;
               chan_in = 1'b0;
            end
            default: step_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         chan_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         chan_ff  <= chan_in;
      end
   end

   `DPSD_ASSERT_IMPLIES(a_idle_at_entry, clock, reset, state_ff == ST_IDLE, step_ff == '0 && !chan_ff, "sequencer idle away from the first step")
   `DPSD_ASSERT_NEXT(a_start_runs, clock, reset, state_ff == ST_IDLE && status.start, state_ff == ST_RUN && step_ff == '0, "accepted item did not start the program")
   `DPSD_ASSERT_NEXT(a_hold_freezes, clock, reset, state_ff == ST_RUN && status.hold, step_ff == $past(step_ff) && state_ff == ST_RUN, "step moved while the result was blocked")

endmodule

`default_nettype wire

[sv/dual_pid_steer_drive.sv]
// ---------------------------------------------------------------------------
// dual_pid_steer_drive
// Steering and drive PID loops sharing one multiplier under a microcoded
// sequencer; one servo and one motor command per control tick.
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    angle_error, distance_error
//  rsp      out        rsp_tvalid/tready    servo_command, motor_command
//  csr      in         csr_valid/ready      csr_index, csr_data
//
//  An item is accepted only while the block is idle: after acceptance a
//  16-step program runs both loops through one shared 24x33 multiplier.
//  The result is registered and appears in the cycle after the last step.
//  Reset clears gains to their defaults, integrals, last errors and the
//  tick counter; there is no clearing pass.
//  A result left untaken stalls only the final step of the next item.
// ---------------------------------------------------------------------------
`default_nettype none

`include "dual_pid_steer_drive_assert.svh"

module dual_pid_steer_drive
   import dpsd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [2*ERR_W-1:0]    req_tdata,   // angle_error, distance_error
   // rsp
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [2*CMD_W-1:0]         rsp_tdata,   // servo_command, motor_command
   // csr
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SUMX_W = SUM_W + 1;
   localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(PID_LIM);
   localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_W'(PID_LIM);
   localparam logic signed [ACC_W-1:0] CMD_MAX = ACC_W'((2 ** CMD_W) - 1);
   localparam logic signed [ACC_W-1:0] THR_MIN = ACC_W'(THROTTLE_MIN);

   // saturating add of an error into an integral
   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [ERR_W-1:0] b
   );
      logic signed [SUMX_W-1:0] s;
      s = SUMX_W'(a) + SUMX_W'(b);
      if (s[SUM_W] != s[SUM_W-1]) begin
         sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sat_add = s[SUM_W-1:0];
      end
   endfunction

   ctrl_type       ctrl;
   seq_status_type status;
   logic           req_fire, fire, post_fire;

   // config registers
   logic signed [GAIN_W-1:0] angle_kp_ff, angle_ki_ff, angle_kd_ff;
   logic signed [GAIN_W-1:0] speed_kp_ff, speed_ki_ff, speed_kd_ff;
   logic signed [ERR_W-1:0]  stop_bound_ff;

   // loop state
   logic signed [SUM_W-1:0]  angle_sum_ff, angle_sum_in;
   logic signed [SUM_W-1:0]  distance_sum_ff, distance_sum_in;
   logic signed [ERR_W-1:0]  last_angle_ff, last_angle_in;
   logic signed [ERR_W-1:0]  last_distance_ff, last_distance_in;
   logic [TICK_W-1:0]        tick_count_ff, tick_count_in;

   // per-item working registers
   logic signed [ERR_W-1:0]  angle_err_ff, angle_err_in;
   logic signed [ERR_W-1:0]  distance_err_ff, distance_err_in;
   logic signed [DIFF_W-1:0] angle_diff_ff, angle_diff_in;
   logic signed [DIFF_W-1:0] distance_diff_ff, distance_diff_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PID_W-1:0]  pid_ff, pid_in;
   logic [CMD_W-1:0]         servo_work_ff, servo_work_in;
   logic [CMD_W-1:0]         motor_work_ff, motor_work_in;
   logic [2*CMD_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // datapath combinational values
   logic signed [GAIN_W-1:0] mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] scaled;
   logic signed [ACC_W-1:0]  cmd_raw;
   logic [CMD_W-1:0]         cmd_sat;
   logic                     period_over;

   dpsd_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // handshakes
   assign req_tready = !ctrl.active;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign status.start = req_fire;
   assign status.hold  = ctrl.active && ctrl.uc.dp_op == DP_POST
                         && rsp_valid_ff && !rsp_tready;
   assign fire      = ctrl.active && !status.hold;
   assign post_fire = fire && ctrl.uc.dp_op == DP_POST;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // multiplier operand select
   always_comb begin
      case (ctrl.uc.mul_a)
         MA_KP:   mul_a = ctrl.chan ? speed_kp_ff : angle_kp_ff;
         MA_KI:   mul_a = ctrl.chan ? speed_ki_ff : angle_ki_ff;
         MA_KD:   mul_a = ctrl.chan ? speed_kd_ff : angle_kd_ff;
         MA_SPAN: mul_a = GAIN_W'(THROTTLE_SPAN);
         default: mul_a = '0;
      endcase
      case (ctrl.uc.mul_b)
         MB_ERR:  mul_b = ctrl.chan ? MB_W'(distance_err_ff) : MB_W'(angle_err_ff);
         MB_SUM:  mul_b = ctrl.chan ? MB_W'(distance_sum_ff) : MB_W'(angle_sum_ff);
         MB_DIFF: mul_b = ctrl.chan ? MB_W'(distance_diff_ff) : MB_W'(angle_diff_ff);
         MB_PID:  mul_b = MB_W'(pid_ff);
         default: mul_b = '0;
      endcase
   end

   // scaled command: floor shift, add the minimum, saturate
   always_comb begin
      scaled  = ctrl.chan ? (prod_ff >>> MOTOR_SHIFT) : (prod_ff >>> SERVO_SHIFT);
      cmd_raw = ACC_W'(scaled) + THR_MIN;
      if (cmd_raw < 0) begin
         cmd_sat = '0;
      end else if (cmd_raw > CMD_MAX) begin
         cmd_sat = '1;
      end else begin
         cmd_sat = cmd_raw[CMD_W-1:0];
      end
   end

   assign period_over = tick_count_ff > TICK_W'(RESET_PERIOD);

   // datapath next values
   always_comb begin
      angle_sum_in     = angle_sum_ff;
      distance_sum_in  = distance_sum_ff;
      last_angle_in    = last_angle_ff;
      last_distance_in = last_distance_ff;
      tick_count_in    = tick_count_ff;
      angle_err_in     = angle_err_ff;
      distance_err_in  = distance_err_ff;
      angle_diff_in    = angle_diff_ff;
      distance_diff_in = distance_diff_ff;
      prod_in          = prod_ff;
      acc_in           = acc_ff;
      pid_in           = pid_ff;
      servo_work_in    = servo_work_ff;
      motor_work_in    = motor_work_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;

      // capture the item
      if (req_fire) begin
         angle_err_in    = req_tdata[ERR_W-1:0];
         distance_err_in = req_tdata[2*ERR_W-1:ERR_W];
      end

      if (fire) begin
         if (ctrl.uc.mul_en) begin
            prod_in = mul_a * mul_b;
         end
         case (ctrl.uc.acc_op)
            ACC_LOAD: acc_in = ACC_W'(prod_ff);
            ACC_ADD:  acc_in = acc_ff + ACC_W'(prod_ff);
            default:  acc_in = acc_ff;
         endcase
         case (ctrl.uc.dp_op)
            // integrals and differences
            DP_PREP: begin
               angle_sum_in     = sat_add(angle_sum_ff, angle_err_ff);
               distance_sum_in  = sat_add(distance_sum_ff, distance_err_ff);
               angle_diff_in    = DIFF_W'(angle_err_ff) - DIFF_W'(last_angle_ff);
               distance_diff_in = DIFF_W'(distance_err_ff) - DIFF_W'(last_distance_ff);
            end
            // bound the PID sum
            DP_CLAMP: begin
               if (acc_ff > ACC_HI) begin
                  pid_in = PID_W'(PID_LIM);
               end else if (acc_ff < ACC_LO) begin
                  pid_in = -PID_W'(PID_LIM);
               end else begin
                  pid_in = acc_ff[PID_W-1:0];
               end
            end
            DP_SCALE: begin
               if (ctrl.chan) motor_work_in = cmd_sat;
               else           servo_work_in = cmd_sat;
            end
            // period reset, stop bound, result out
            DP_POST: begin
               if (period_over) begin
                  angle_sum_in    = '0;
                  distance_sum_in = '0;
               end
               if (distance_err_ff < stop_bound_ff) begin
                  distance_sum_in = '0;
                  rsp_data_in = {CMD_W'(THROTTLE_MIN), servo_work_ff};
               end else begin
                  rsp_data_in = {motor_work_ff, servo_work_ff};
               end
               tick_count_in    = period_over ? TICK_W'(1) : TICK_W'(tick_count_ff + 1'b1);
               last_angle_in    = angle_err_ff;
               last_distance_in = distance_err_ff;
               rsp_valid_in     = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // control state and config
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_kp_ff      <= ANGLE_KP_RST;
         angle_ki_ff      <= ANGLE_KI_RST;
         angle_kd_ff      <= ANGLE_KD_RST;
         speed_kp_ff      <= SPEED_KP_RST;
         speed_ki_ff      <= SPEED_KI_RST;
         speed_kd_ff      <= SPEED_KD_RST;
         stop_bound_ff    <= STOP_BOUND_RST;
         angle_sum_ff     <= '0;
         distance_sum_ff  <= '0;
         last_angle_ff    <= '0;
         last_distance_ff <= '0;
         tick_count_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ANGLE_KP:   angle_kp_ff   <= csr_data;
               CSR_ANGLE_KI:   angle_ki_ff   <= csr_data;
               CSR_ANGLE_KD:   angle_kd_ff   <= csr_data;
               CSR_SPEED_KP:   speed_kp_ff   <= csr_data;
               CSR_SPEED_KI:   speed_ki_ff   <= csr_data;
               CSR_SPEED_KD:   speed_kd_ff   <= csr_data;
               CSR_STOP_BOUND: stop_bound_ff <= csr_data[ERR_W-1:0];
               default: ;
            endcase
         end
         angle_sum_ff     <= angle_sum_in;
         distance_sum_ff  <= distance_sum_in;
         last_angle_ff    <= last_angle_in;
         last_distance_ff <= last_distance_in;
         tick_count_ff    <= tick_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      angle_err_ff     <= angle_err_in;
      distance_err_ff  <= distance_err_in;
      angle_diff_ff    <= angle_diff_in;
      distance_diff_ff <= distance_diff_in;
      prod_ff          <= prod_in;
      acc_ff           <= acc_in;
      pid_ff           <= pid_in;
      servo_work_ff    <= servo_work_in;
      motor_work_ff    <= motor_work_in;
      rsp_data_ff      <= rsp_data_in;
   end

   `DPSD_ASSERT_IMPLIES(a_pid_bounded, clock, reset, fire && ctrl.uc.mul_b == MB_PID && ctrl.uc.mul_en, pid_ff <= PID_W'(PID_LIM) && pid_ff >= -PID_W'(PID_LIM), "clamped PID sum out of range")
   `DPSD_ASSERT_HOLDS(a_tick_bounded, clock, reset, {1'b0, tick_count_ff} <= (TICK_W + 1)'(RESET_PERIOD + 1), "tick counter past the reset period")
   `DPSD_ASSERT_NEXT(a_post_shows_result, clock, reset, post_fire, rsp_tvalid, "final step did not present a result")

endmodule

`default_nettype wire
